// File: rtl/core/mexp_pkg.sv
// Package for the modular exponentiation block: fixed field widths,
// configuration register codes and reset values.
// No dependencies; used by every file under rtl/core except mexp_mul_cell.
`default_nettype none

package mexp_pkg;

  // Fixed widths of the message and result fields
  localparam int MSG_W = 20;
  localparam int OUT_W = 20;

  // Configuration port index width
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS  = 2'd0,
    REG_EXPONENT = 2'd1
  } cfg_reg_t;

  // Register reset values (truncated to the register width at use)
  localparam int MODULUS_RESET  = 1147;
  localparam int EXPONENT_RESET = 1;

endpackage

`default_nettype wire

// File: rtl/core/mexp_red_cell.sv
// Reduction cell: one restoring step of message mod modulus, one message
// bit per cell, most significant bit first.
// Depends on mexp_pkg (message width).
`default_nettype none

module mexp_red_cell #(
  parameter int MOD_WIDTH = 20,
  parameter int BIT_IDX   = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic [MOD_WIDTH-1:0]          modulus,
  input  wire logic                          vld_i,
  input  wire logic [mexp_pkg::MSG_W-1:0]    msg_i,
  input  wire logic [MOD_WIDTH-1:0]          rem_i,
  output logic                               vld_o,
  output logic [mexp_pkg::MSG_W-1:0]         msg_o,
  output logic [MOD_WIDTH-1:0]               rem_o
);

  logic                       vld_r;
  logic [mexp_pkg::MSG_W-1:0] msg_r;
  logic [MOD_WIDTH-1:0]       rem_r;
  logic [MOD_WIDTH:0]         shifted;
  logic [MOD_WIDTH-1:0]       rem_nxt;

  // Shift in the next message bit and subtract the modulus once if needed
  always_comb begin
    shifted = {rem_i, msg_i[BIT_IDX]};
    if (shifted >= {1'b0, modulus}) begin
      rem_nxt = MOD_WIDTH'(shifted - {1'b0, modulus});
    end else begin
      rem_nxt = shifted[MOD_WIDTH-1:0];
    end
  end

  // Hold valid under reset; advance on enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  // Advance payload on enable
  always_ff @(posedge clk) begin
    if (en) begin
      msg_r <= msg_i;
      rem_r <= rem_nxt;
    end
  end

  assign vld_o = vld_r;
  assign msg_o = msg_r;
  assign rem_o = rem_r;

endmodule

`default_nettype wire

// File: rtl/core/mexp_mul_cell.sv
// Multiply cell: one interleaved modular multiply step for both the
// accumulator product (acc * sq) and the square (sq * sq), one multiplier
// bit per cell. The cell at bit zero closes one exponent bit.
// No package dependencies.
`default_nettype none

module mexp_mul_cell #(
  parameter int MOD_WIDTH = 20,
  parameter int BIT_IDX   = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic [MOD_WIDTH-1:0] modulus,
  input  wire logic                 exp_bit,
  input  wire logic                 vld_i,
  input  wire logic [MOD_WIDTH-1:0] acc_i,
  input  wire logic [MOD_WIDTH-1:0] sq_i,
  input  wire logic [MOD_WIDTH-1:0] pm_i,
  input  wire logic [MOD_WIDTH-1:0] ps_i,
  output logic                      vld_o,
  output logic [MOD_WIDTH-1:0]      acc_o,
  output logic [MOD_WIDTH-1:0]      sq_o,
  output logic [MOD_WIDTH-1:0]      pm_o,
  output logic [MOD_WIDTH-1:0]      ps_o
);

  localparam bit LAST = (BIT_IDX == 0);

  logic                 vld_r;
  logic [MOD_WIDTH-1:0] acc_r, sq_r, pm_r, ps_r;
  logic [MOD_WIDTH-1:0] acc_nxt, sq_nxt, pm_nxt, ps_nxt;
  logic [MOD_WIDTH-1:0] pm_step, ps_step;

  // One step: r = 2r + (bit ? a : 0), then bring back below the modulus.
  // Both r and a are below n, so at most two subtractions are needed.
  function automatic logic [MOD_WIDTH-1:0] mul_step(
    input logic [MOD_WIDTH-1:0] r,
    input logic [MOD_WIDTH-1:0] a,
    input logic                 b,
    input logic [MOD_WIDTH-1:0] n
  );
    logic [MOD_WIDTH+1:0] t;
    logic [MOD_WIDTH+1:0] n1;
    logic [MOD_WIDTH+1:0] n2;
    logic [MOD_WIDTH+1:0] res;
    t  = {1'b0, r, 1'b0} + (b ? {2'b00, a} : '0);
    n1 = {2'b00, n};
    n2 = {1'b0, n, 1'b0};
    priority if (t >= n2) begin
      res = t - n2;
    end else if (t >= n1) begin
      res = t - n1;
    end else begin
      res = t;
    end
    return res[MOD_WIDTH-1:0];
  endfunction

  // Run both products; at bit zero fold the products into acc and sq
  always_comb begin
    pm_step = mul_step(pm_i, sq_i, acc_i[BIT_IDX], modulus);
    ps_step = mul_step(ps_i, sq_i, sq_i[BIT_IDX], modulus);
    if (LAST) begin
      acc_nxt = exp_bit ? pm_step : acc_i;
      sq_nxt  = ps_step;
      pm_nxt  = '0;
      ps_nxt  = '0;
    end else begin
      acc_nxt = acc_i;
      sq_nxt  = sq_i;
      pm_nxt  = pm_step;
      ps_nxt  = ps_step;
    end
  end

  // Hold valid under reset; advance on enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  // Advance payload on enable
  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
      sq_r  <= sq_nxt;
      pm_r  <= pm_nxt;
      ps_r  <= ps_nxt;
    end
  end

  assign vld_o = vld_r;
  assign acc_o = acc_r;
  assign sq_o  = sq_r;
  assign pm_o  = pm_r;
  assign ps_o  = ps_r;

endmodule

`default_nettype wire

// File: rtl/core/modular_exponentiation.sv
// Top level of the modular exponentiation block: configuration registers,
// reduction cell chain, multiply cell chain and output register.
// Depends on mexp_pkg, mexp_red_cell and mexp_mul_cell.
`default_nettype none

// Computes in_message ** exponent mod modulus with the right-to-left binary
// method and accepts one message every clock cycle while in_stall is low.
// A chain of 20 reduction cells brings the message below the modulus one
// bit per cell, then each exponent bit takes MOD_WIDTH multiply cells,
// each of which consumes one multiplier bit of both the square and the
// product. The whole chain freezes only when the output register holds a
// result that is stalled and another result has reached the end of the
// chain. A modulus of zero or one gives a result of zero. Write the
// configuration only while no message is in flight.
module modular_exponentiation #(
  parameter int MOD_WIDTH = 20,
  parameter int EXP_WIDTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // Configuration write port
  input  wire logic                                   cfg_wr_en,
  input  wire logic [mexp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [((MOD_WIDTH > EXP_WIDTH) ? MOD_WIDTH : EXP_WIDTH)-1:0] cfg_wdata,
  // Message input
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [mexp_pkg::MSG_W-1:0]             in_message,
  // Result output
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [mexp_pkg::OUT_W-1:0]                  out_power_result
);

  localparam int MSG_W  = mexp_pkg::MSG_W;
  localparam int OUT_W  = mexp_pkg::OUT_W;
  localparam int NSTEP  = MOD_WIDTH * EXP_WIDTH;

  // Configuration registers
  logic [MOD_WIDTH-1:0] mod_r;
  logic [EXP_WIDTH-1:0] exp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= MOD_WIDTH'(mexp_pkg::MODULUS_RESET);
      exp_r <= EXP_WIDTH'(mexp_pkg::EXPONENT_RESET);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mexp_pkg::REG_MODULUS:  mod_r <= cfg_wdata[MOD_WIDTH-1:0];
        mexp_pkg::REG_EXPONENT: exp_r <= cfg_wdata[EXP_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Chain control: freeze only when the end of the chain cannot drain
  logic out_valid_r;
  logic out_take;
  logic chain_en;
  logic last_vld;

  assign out_take = !out_valid_r || !out_stall;
  assign chain_en = !last_vld || out_take;
  assign in_stall = !chain_en;

  // Reduction chain, message bits MSB first
  logic                 red_vld [0:MSG_W];
  logic [MSG_W-1:0]     red_msg [0:MSG_W];
  logic [MOD_WIDTH-1:0] red_rem [0:MSG_W];

  assign red_vld[0] = in_valid;
  assign red_msg[0] = in_message;
  assign red_rem[0] = '0;

  for (genvar i = 0; i < MSG_W; i++) begin : g_red
    mexp_red_cell #(
      .MOD_WIDTH (MOD_WIDTH),
      .BIT_IDX   (MSG_W - 1 - i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (chain_en),
      .modulus (mod_r),
      .vld_i   (red_vld[i]),
      .msg_i   (red_msg[i]),
      .rem_i   (red_rem[i]),
      .vld_o   (red_vld[i+1]),
      .msg_o   (red_msg[i+1]),
      .rem_o   (red_rem[i+1])
    );
  end

  // Multiply chain: MOD_WIDTH cells per exponent bit, LSB exponent bit first
  logic                 mul_vld [0:NSTEP];
  logic [MOD_WIDTH-1:0] mul_acc [0:NSTEP];
  logic [MOD_WIDTH-1:0] mul_sq  [0:NSTEP];
  logic [MOD_WIDTH-1:0] mul_pm  [0:NSTEP];
  logic [MOD_WIDTH-1:0] mul_ps  [0:NSTEP];

  // Seed: square is the reduced message, accumulator is one
  assign mul_vld[0] = red_vld[MSG_W];
  assign mul_acc[0] = MOD_WIDTH'(1);
  assign mul_sq[0]  = red_rem[MSG_W];
  assign mul_pm[0]  = '0;
  assign mul_ps[0]  = '0;

  for (genvar k = 0; k < EXP_WIDTH; k++) begin : g_exp
    for (genvar j = 0; j < MOD_WIDTH; j++) begin : g_bit
      mexp_mul_cell #(
        .MOD_WIDTH (MOD_WIDTH),
        .BIT_IDX   (MOD_WIDTH - 1 - j)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (chain_en),
        .modulus (mod_r),
        .exp_bit (exp_r[k]),
        .vld_i   (mul_vld[k*MOD_WIDTH + j]),
        .acc_i   (mul_acc[k*MOD_WIDTH + j]),
        .sq_i    (mul_sq[k*MOD_WIDTH + j]),
        .pm_i    (mul_pm[k*MOD_WIDTH + j]),
        .ps_i    (mul_ps[k*MOD_WIDTH + j]),
        .vld_o   (mul_vld[k*MOD_WIDTH + j + 1]),
        .acc_o   (mul_acc[k*MOD_WIDTH + j + 1]),
        .sq_o    (mul_sq[k*MOD_WIDTH + j + 1]),
        .pm_o    (mul_pm[k*MOD_WIDTH + j + 1]),
        .ps_o    (mul_ps[k*MOD_WIDTH + j + 1])
      );
    end
  end

  assign last_vld = mul_vld[NSTEP];

  // Final result: zero for a degenerate modulus, fit to the output width
  logic [OUT_W+MOD_WIDTH-1:0] acc_ext;
  logic [OUT_W-1:0]           result_nxt;

  always_comb begin
    acc_ext = {{OUT_W{1'b0}}, mul_acc[NSTEP]};
    if (mod_r < MOD_WIDTH'(2)) begin
      result_nxt = '0;
    end else begin
      result_nxt = acc_ext[OUT_W-1:0];
    end
  end

  // Output register: load whenever the current result is taken or empty
  logic [OUT_W-1:0] out_result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= last_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_result_r <= result_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_power_result = out_result_r;

endmodule

`default_nettype wire

// File: rtl/core/mexp_checker.sv
// Port-level checker for the modular exponentiation block, and the bind
// that attaches it to the top level.
// Depends on mexp_pkg and modular_exponentiation.
`default_nettype none

module mexp_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [mexp_pkg::OUT_W-1:0] out_power_result
);

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Input is blocked only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_power_result)))
    else $error("stalled result changed or dropped");

  // A result leaves only through a transfer
  a_out_leave: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(!out_stall))
    else $error("result dropped without transfer");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_power_result (out_power_result)
);

`default_nettype wire
